@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the scanner modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the standard clk_i / rst_ni pair.
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ hw/rtl/xbbs_pkg.sv @@
// ----------------------------------------------------------------------------
// xbbs_pkg
// Types, opcode constants and the length decoder of the branch block scanner.
// ----------------------------------------------------------------------------
package xbbs_pkg;

  typedef enum logic [1:0] {
    REC_STEP    = 2'd0,
    REC_SYSCALL = 2'd1,
    REC_BLOCK   = 2'd2,
    REC_LOOP    = 2'd3
  } rec_kind_e;

  typedef enum logic [1:0] {
    PH_DEC = 2'd0,
    PH_ADR = 2'd1,
    PH_EMT = 2'd2
  } phase_e;

  localparam logic CFG_CODE_BASE = 1'b0;
  localparam logic CFG_CODE_SIZE = 1'b1;

  localparam logic [7:0] OP_TWO_BYTE = 8'h0F;
  localparam logic [7:0] OP_SYSCALL2 = 8'h05;
  localparam logic [7:0] OP_NOP_MODRM = 8'h1F;
  localparam logic [7:0] OP_RET = 8'hC3;
  localparam logic [7:0] OP_RET_FAR = 8'hCB;
  localparam logic [7:0] OP_INT3 = 8'hCC;
  localparam logic [7:0] OP_NOP = 8'h90;
  localparam logic [7:0] OP_CALL = 8'hE8;
  localparam logic [7:0] OP_JMP32 = 8'hE9;
  localparam logic [7:0] OP_JMP8 = 8'hEB;
  localparam logic [7:0] OP_REX_LO = 8'h40;
  localparam logic [7:0] OP_REX_HI = 8'h4F;
  localparam logic [7:0] OP_PUSHPOP_LO = 8'h50;
  localparam logic [7:0] OP_PUSHPOP_HI = 8'h5F;
  localparam logic [7:0] OP_JCC8_LO = 8'h70;
  localparam logic [7:0] OP_JCC8_HI = 8'h7F;
  localparam logic [7:0] OP_JCC32_LO = 8'h80;
  localparam logic [7:0] OP_JCC32_HI = 8'h8F;
  localparam logic [7:0] OP_GRP1_IB = 8'h80;
  localparam logic [7:0] OP_GRP1_IZ = 8'h81;
  localparam logic [7:0] OP_GRP1_IB2 = 8'h82;
  localparam logic [7:0] OP_GRP1_SIB = 8'h83;
  localparam logic [7:0] OP_MOV_ST = 8'h89;
  localparam logic [7:0] OP_MOV_LD = 8'h8B;
  localparam logic [7:0] OP_LEA = 8'h8D;
  localparam logic [7:0] OP_XOR_ST = 8'h31;
  localparam logic [7:0] OP_XOR_LD = 8'h33;
  localparam logic [7:0] OP_CMP_ST = 8'h39;
  localparam logic [7:0] OP_CMP_LD = 8'h3B;
  localparam logic [7:0] OP_TEST = 8'h85;
  localparam logic [7:0] OP_ADD_ST = 8'h01;
  localparam logic [7:0] OP_ADD_LD = 8'h03;
  localparam logic [7:0] OP_SUB_ST = 8'h29;
  localparam logic [7:0] OP_OR_ST = 8'h09;
  localparam logic [7:0] OP_OR_LD = 8'h0B;
  localparam logic [7:0] OP_AND_ST = 8'h21;
  localparam logic [7:0] OP_AND_LD = 8'h23;
  localparam logic [7:0] OP_GRP5 = 8'hFF;
  localparam logic [7:0] OP_MOVI_LO = 8'hB8;
  localparam logic [7:0] OP_MOVI_HI = 8'hBF;
  localparam logic [7:0] OP_MOVB_LO = 8'hB0;
  localparam logic [7:0] OP_MOVB_HI = 8'hB7;

  localparam logic [1:0] MOD_NONE = 2'd0;
  localparam logic [1:0] MOD_D8 = 2'd1;
  localparam logic [1:0] MOD_D32 = 2'd2;
  localparam logic [1:0] MOD_REG = 2'd3;
  localparam logic [2:0] RM_SIB = 3'd4;
  localparam logic [2:0] RM_RIP = 3'd5;

  typedef struct packed {
    logic [3:0]  len;
    logic        is_sys;
    logic        is_ret;
    logic        is_rel8;
    logic        is_rel32;
    logic        is_call;
    logic        is_jcc32;
    logic [63:0] disp;
  } dec_t;

  typedef struct packed {
    logic [3:0]  insn_len;
    logic [32:0] next_offset;
    logic        scan_done;
    logic        has_sys;
    logic        has_blk;
    logic        has_loop;
    logic [63:0] sys_addr;
    logic [63:0] blk_start;
    logic [63:0] blk_end;
    logic [63:0] blk_target;
    logic        blk_call;
    logic        blk_ret;
  } bundle_t;

  // gt[k] is set when more than k text bytes remain at the window start.
  function automatic dec_t xbbs_decode(logic [63:0] w, logic [6:0] gt);
    dec_t        d;
    logic        rex;
    logic [63:0] ws;
    logic [6:0]  g;
    logic [7:0]  op;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [3:0]  r;
    logic [3:0]  sib;
    logic [3:0]  len;
    logic        modrm_op;
    d   = '0;
    rex = (w[7:0] >= OP_REX_LO) && (w[7:0] <= OP_REX_HI) && gt[1];
    ws  = rex ? {8'h00, w[63:8]} : w;
    g   = rex ? {1'b0, gt[6:1]} : gt;
    op  = ws[7:0];
    b1  = ws[15:8];
    b2  = ws[23:16];
    r   = {3'b000, rex};
    sib = 4'd0;
    modrm_op = ((op >= OP_GRP1_IB) && (op <= OP_GRP1_SIB)) || (op == OP_MOV_ST) ||
               (op == OP_MOV_LD) || (op == OP_LEA) || (op == OP_XOR_ST) ||
               (op == OP_XOR_LD) || (op == OP_CMP_ST) || (op == OP_CMP_LD) ||
               (op == OP_TEST) || (op == OP_ADD_ST) || (op == OP_ADD_LD) ||
               (op == OP_SUB_ST) || (op == OP_OR_ST) || (op == OP_OR_LD) ||
               (op == OP_AND_ST) || (op == OP_AND_LD) || (op == OP_GRP5);
    priority if ((op == OP_RET) || (op == OP_RET_FAR) || (op == OP_INT3) ||
                 (op == OP_NOP)) begin
      len = r + 4'd1;
    end else if ((op >= OP_PUSHPOP_LO) && (op <= OP_PUSHPOP_HI)) begin
      len = r + 4'd1;
    end else if (((op >= OP_JCC8_LO) && (op <= OP_JCC8_HI)) || (op == OP_JMP8)) begin
      len = r + 4'd2;
    end else if ((op == OP_CALL) || (op == OP_JMP32)) begin
      len = r + 4'd5;
    end else if ((op == OP_TWO_BYTE) && g[1]) begin
      if (b2[2:0] == RM_SIB) begin
        sib = 4'd1;
      end
      priority if (b1 == OP_SYSCALL2) begin
        len = r + 4'd2;
      end else if ((b1 >= OP_JCC32_LO) && (b1 <= OP_JCC32_HI)) begin
        len = r + 4'd6;
      end else if ((b1 == OP_NOP_MODRM) && g[2] && (b2[7:6] == MOD_NONE)) begin
        len = r + 4'd3 + sib;
      end else if ((b1 == OP_NOP_MODRM) && g[2] && (b2[7:6] == MOD_D8)) begin
        len = r + 4'd4 + sib;
      end else if ((b1 == OP_NOP_MODRM) && g[2] && (b2[7:6] == MOD_D32)) begin
        len = r + 4'd7 + sib;
      end else begin
        len = r + 4'd3;
      end
    end else if (modrm_op) begin
      len = r + 4'd2;
      if (g[1]) begin
        if ((b1[2:0] == RM_SIB) && (b1[7:6] != MOD_REG)) len = len + 4'd1;
        if (b1[7:6] == MOD_D8) len = len + 4'd1;
        if ((b1[7:6] == MOD_D32) || ((b1[7:6] == MOD_NONE) && (b1[2:0] == RM_RIP))) begin
          len = len + 4'd4;
        end
        if ((op == OP_GRP1_IB) || (op == OP_GRP1_IB2) || (op == OP_GRP1_SIB)) begin
          len = len + 4'd1;
        end
        if (op == OP_GRP1_IZ) len = len + 4'd4;
      end
    end else if ((op >= OP_MOVI_LO) && (op <= OP_MOVI_HI)) begin
      len = rex ? 4'd10 : 4'd5;
    end else if ((op >= OP_MOVB_LO) && (op <= OP_MOVB_HI)) begin
      len = r + 4'd2;
    end else begin
      len = r + 4'd3;
    end
    d.len      = len;
    d.is_sys   = (op == OP_TWO_BYTE) && g[1] && (b1 == OP_SYSCALL2);
    d.is_ret   = (op == OP_RET) || (op == OP_RET_FAR);
    d.is_rel8  = ((op >= OP_JCC8_LO) && (op <= OP_JCC8_HI)) || (op == OP_JMP8);
    d.is_rel32 = (op == OP_CALL) || (op == OP_JMP32);
    d.is_call  = (op == OP_CALL);
    d.is_jcc32 = (op == OP_TWO_BYTE) && g[5] && (b1 >= OP_JCC32_LO) && (b1 <= OP_JCC32_HI);
    if (d.is_rel8) begin
      d.disp = {{56{b1[7]}}, b1};
    end else if (d.is_rel32) begin
      d.disp = {{32{ws[39]}}, ws[39:8]};
    end else if (d.is_jcc32) begin
      d.disp = {{32{ws[47]}}, ws[47:16]};
    end
    return d;
  endfunction

endpackage

@@ hw/rtl/xbbs_front.sv @@
// ----------------------------------------------------------------------------
// xbbs_front
// Input buffer, three-phase instruction decoder and scan state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xbbs_front #(
  parameter int unsigned MAX_BLOCKS   = 4096,
  parameter int unsigned MAX_SYSCALLS = 256,
  parameter int unsigned MAX_LOOPS    = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [63:0]       code_window_i,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [63:0]       cfg_wdata_i,
  output logic              q_push_o,
  output xbbs_pkg::bundle_t q_data_o,
  input  logic              q_full_i
);
  import xbbs_pkg::*;

  localparam int unsigned BW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SW = $clog2(MAX_SYSCALLS + 1);
  localparam int unsigned LW = $clog2(MAX_LOOPS + 1);
  localparam logic [BW-1:0] BlkLast = BW'(MAX_BLOCKS - 1);
  localparam logic [BW-1:0] BlkMax  = BW'(MAX_BLOCKS);
  localparam logic [SW-1:0] SysMax  = SW'(MAX_SYSCALLS);
  localparam logic [LW-1:0] LoopMax = LW'(MAX_LOOPS);

  logic [63:0] base_q;
  logic [31:0] size_q;

  logic        buf_valid_q, buf_valid_d;
  logic [63:0] buf_win_q;
  logic        take;

  phase_e phase_q, phase_d;

  logic [32:0]   off_q, off_d;
  logic [63:0]   obs_q, obs_d;
  logic [BW-1:0] bt_q, bt_d;
  logic [SW-1:0] st_q, st_d;
  logic [LW-1:0] lt_q, lt_d;
  logic          fin_q, fin_d;

  // Decode phase results.
  dec_t        dec_q;
  logic [63:0] va_q;
  logic [63:0] disp_len_q;
  logic [32:0] new_off_q;
  logic [63:0] start_q;
  logic        active_q;
  logic        was_fin_q;

  // Address phase results.
  logic [63:0] tgt_q;
  logic [63:0] end_q;

  logic        active;
  logic [31:0] rem;
  logic [6:0]  gt;
  dec_t        dec;

  logic          br;
  logic          has_tgt;
  logic [63:0]   target;
  logic          has_sys;
  logic          has_loop;
  logic [BW-1:0] bt1;
  logic          done;
  logic          trail;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      size_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CODE_BASE: base_q <= cfg_wdata_i;
        CFG_CODE_SIZE: size_q <= cfg_wdata_i[31:0];
        default:       base_q <= base_q;
      endcase
    end
  end

  // Phase sequencing.
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_DEC: if (buf_valid_q) phase_d = PH_ADR;
      PH_ADR: phase_d = PH_EMT;
      PH_EMT: if (!q_full_i) phase_d = PH_DEC;
      default: phase_d = PH_DEC;
    endcase
  end

  always_comb begin
    take     = buf_valid_q && (phase_q == PH_DEC);
    q_push_o = (phase_q == PH_EMT) && !q_full_i;
  end

  assign in_stall_o  = buf_valid_q && !take;
  assign buf_valid_d = (in_valid_i && !in_stall_o) ? 1'b1 : (take ? 1'b0 : buf_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
      phase_q     <= PH_DEC;
    end else begin
      buf_valid_q <= buf_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      buf_win_q <= code_window_i;
    end
  end

  // Decode phase: length, branch class and the first address sums.
  always_comb begin
    active = !fin_q && (off_q < {1'b0, size_q}) && (bt_q < BlkLast);
    rem    = size_q - off_q[31:0];
    for (int k = 0; k < 7; k++) begin
      gt[k] = rem > 32'(k);
    end
    dec = xbbs_decode(buf_win_q, gt);
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      dec_q      <= dec;
      va_q       <= base_q + {31'b0, off_q};
      disp_len_q <= dec.disp + {60'b0, dec.len};
      new_off_q  <= active ? (off_q + {29'b0, dec.len}) : off_q;
      start_q    <= (off_q == 33'd0) ? base_q : obs_q;
      active_q   <= active;
      was_fin_q  <= fin_q;
    end
    if (phase_q == PH_ADR) begin
      tgt_q <= va_q + disp_len_q;
      end_q <= base_q + {31'b0, new_off_q};
    end
  end

  // Record phase: block, loop and syscall decisions, and the state update.
  always_comb begin
    br = active_q && (dec_q.is_sys || dec_q.is_ret || dec_q.is_rel8 ||
                      dec_q.is_rel32 || dec_q.is_jcc32);
    has_tgt  = br && (dec_q.is_rel8 || dec_q.is_rel32 || dec_q.is_jcc32);
    target   = has_tgt ? tgt_q : 64'd0;
    has_sys  = active_q && dec_q.is_sys && (st_q < SysMax);
    has_loop = br && (target != 64'd0) && (target < end_q) && (target >= base_q) &&
               !(dec_q.is_call && dec_q.is_rel32) && !dec_q.is_ret && (lt_q < LoopMax);
    bt1      = bt_q + BW'(br);
    done     = was_fin_q || !((new_off_q < {1'b0, size_q}) && (bt1 < BlkLast));
    // A branch leaves the open block empty, so only a non-branch step closes a tail.
    trail    = !was_fin_q && done && !br && (start_q < end_q) && (bt1 < BlkMax);

    q_data_o.insn_len    = active_q ? dec_q.len : 4'd0;
    q_data_o.next_offset = new_off_q;
    q_data_o.scan_done   = done;
    q_data_o.has_sys     = has_sys;
    q_data_o.has_blk     = br || trail;
    q_data_o.has_loop    = has_loop;
    q_data_o.sys_addr    = va_q;
    q_data_o.blk_start   = start_q;
    q_data_o.blk_end     = end_q;
    q_data_o.blk_target  = target;
    q_data_o.blk_call    = br && dec_q.is_rel32 && dec_q.is_call;
    q_data_o.blk_ret     = br && dec_q.is_ret;

    off_d = off_q;
    obs_d = obs_q;
    bt_d  = bt_q;
    st_d  = st_q;
    lt_d  = lt_q;
    fin_d = fin_q;
    if (q_push_o && !was_fin_q) begin
      off_d = new_off_q;
      obs_d = br ? end_q : start_q;
      bt_d  = bt1 + BW'(trail);
      st_d  = st_q + SW'(has_sys);
      lt_d  = lt_q + LW'(has_loop);
      fin_d = done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
      obs_q <= '0;
      bt_q  <= '0;
      st_q  <= '0;
      lt_q  <= '0;
      fin_q <= 1'b0;
    end else begin
      off_q <= off_d;
      obs_q <= obs_d;
      bt_q  <= bt_d;
      st_q  <= st_d;
      lt_q  <= lt_d;
      fin_q <= fin_d;
    end
  end

  `ASSERT_STD(a_fin_sticky, fin_q |=> fin_q, "scan finished flag dropped")
  `ASSERT_STD(a_loop_alone,
    (q_push_o && q_data_o.has_loop) |-> (q_data_o.has_blk && !q_data_o.has_sys),
    "loop record without its block")
  `ASSERT_STD(a_blk_bound, bt_q <= BlkMax, "block count beyond its limit")

endmodule

@@ hw/rtl/xbbs_queue.sv @@
// ----------------------------------------------------------------------------
// xbbs_queue
// Two-entry queue of per-item record bundles between decoder and emitter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xbbs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  xbbs_pkg::bundle_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output xbbs_pkg::bundle_t data_o
);
  import xbbs_pkg::*;

  bundle_t     mem_q [2];
  logic        wr_q, wr_d;
  logic        rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `ASSERT_STD(a_no_overflow, push_i |-> (cnt_q != 2'd2), "push into a full queue")
  `ASSERT_STD(a_no_underflow, pop_i |-> (cnt_q != 2'd0), "pop from an empty queue")

endmodule

@@ hw/rtl/xbbs_back.sv @@
// ----------------------------------------------------------------------------
// xbbs_back
// Record emitter: turns one bundle into its step, syscall, block and loop items.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xbbs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  xbbs_pkg::bundle_t q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        record_kind_o,
  output logic [63:0]       first_addr_o,
  output logic [63:0]       second_addr_o,
  output logic [63:0]       third_addr_o,
  output logic              ends_with_call_o,
  output logic              ends_with_ret_o,
  output logic [3:0]        insn_len_o,
  output logic [32:0]       next_offset_o,
  output logic              scan_done_o,
  output logic              last_of_run_o
);
  import xbbs_pkg::*;

  rec_kind_e   sel_q, sel_d;
  logic        valid_q, valid_d;
  logic        load;
  logic [3:0]  present;
  logic [3:0]  above;
  logic [3:0]  remain;
  logic        last;

  rec_kind_e   kind_d;
  logic [63:0] a1_d, a2_d, a3_d;
  logic        call_d, ret_d;
  logic [3:0]  len_d;
  logic [32:0] next_d;
  logic        done_d;

  always_comb begin
    present = {q_data_i.has_loop, q_data_i.has_blk, q_data_i.has_sys, 1'b1};
    unique case (sel_q)
      REC_STEP:    above = 4'b1110;
      REC_SYSCALL: above = 4'b1100;
      REC_BLOCK:   above = 4'b1000;
      REC_LOOP:    above = 4'b0000;
      default:     above = 4'b0000;
    endcase
    remain  = present & above;
    last    = (remain == 4'b0000);
    load    = q_valid_i && (!valid_q || !out_stall_i);
    q_pop_o = load && last;
    valid_d = load ? 1'b1 : (valid_q && out_stall_i);

    sel_d = sel_q;
    if (load) begin
      priority if (last) begin
        sel_d = REC_STEP;
      end else if (remain[1]) begin
        sel_d = REC_SYSCALL;
      end else if (remain[2]) begin
        sel_d = REC_BLOCK;
      end else begin
        sel_d = REC_LOOP;
      end
    end
  end

  // Field selection for the record being loaded.
  always_comb begin
    kind_d = sel_q;
    a1_d   = '0;
    a2_d   = '0;
    a3_d   = '0;
    call_d = 1'b0;
    ret_d  = 1'b0;
    len_d  = '0;
    next_d = '0;
    done_d = 1'b0;
    unique case (sel_q)
      REC_STEP: begin
        len_d  = q_data_i.insn_len;
        next_d = q_data_i.next_offset;
        done_d = q_data_i.scan_done;
      end
      REC_SYSCALL: begin
        a1_d = q_data_i.sys_addr;
      end
      REC_BLOCK: begin
        a1_d   = q_data_i.blk_start;
        a2_d   = q_data_i.blk_end;
        a3_d   = q_data_i.blk_target;
        call_d = q_data_i.blk_call;
        ret_d  = q_data_i.blk_ret;
      end
      REC_LOOP: begin
        a1_d = q_data_i.blk_target;
        a2_d = q_data_i.blk_start;
        a3_d = q_data_i.blk_end;
      end
      default: kind_d = REC_STEP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q   <= REC_STEP;
      valid_q <= 1'b0;
    end else begin
      sel_q   <= sel_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      record_kind_o    <= kind_d;
      first_addr_o     <= a1_d;
      second_addr_o    <= a2_d;
      third_addr_o     <= a3_d;
      ends_with_call_o <= call_d;
      ends_with_ret_o  <= ret_d;
      insn_len_o       <= len_d;
      next_offset_o    <= next_d;
      scan_done_o      <= done_d;
      last_of_run_o    <= last;
    end
  end

  assign out_valid_o = valid_q;

  `ASSERT_STD(a_loop_last,
    (valid_q && (record_kind_o == REC_LOOP)) |-> last_of_run_o,
    "loop record not final")

endmodule

@@ hw/rtl/x86_branch_block_scanner.sv @@
// ----------------------------------------------------------------------------
// x86_branch_block_scanner
// Approximate x86-64 length predecode with basic block, syscall and loop finding.
// ----------------------------------------------------------------------------
// Each item is the 8-byte window at the offset given by the previous step
// record's next_offset. The decoder takes an item through its length decode,
// address sums and record build phases, and a one-item input buffer takes
// the following window meanwhile. Results leave one per cycle from an output
// register while out_stall_i is low; an item gives one to three results, so
// the decoder sets the sustained rate while the output takes a result every
// cycle, and output stalls slow it down once the two-entry queue between
// decoder and emitter has filled. The step record of an item is offered
// first, once the item has passed the decode, address and emit phases and the
// queue. Write the configuration only while no item is in flight.

module x86_branch_block_scanner #(
  parameter int unsigned MAX_BLOCKS   = 4096,
  parameter int unsigned MAX_SYSCALLS = 256,
  parameter int unsigned MAX_LOOPS    = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] code_window_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  record_kind_o,
  output logic [63:0] first_addr_o,
  output logic [63:0] second_addr_o,
  output logic [63:0] third_addr_o,
  output logic        ends_with_call_o,
  output logic        ends_with_ret_o,
  output logic [3:0]  insn_len_o,
  output logic [32:0] next_offset_o,
  output logic        scan_done_o,
  output logic        last_of_run_o
);
  import xbbs_pkg::*;

  logic    push, full, pop, qvalid;
  bundle_t push_data, head_data;

  xbbs_front #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .MAX_SYSCALLS(MAX_SYSCALLS),
    .MAX_LOOPS   (MAX_LOOPS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .code_window_i(code_window_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_push_o     (push),
    .q_data_o     (push_data),
    .q_full_i     (full)
  );

  xbbs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(qvalid),
    .data_o (head_data)
  );

  xbbs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (qvalid),
    .q_data_i        (head_data),
    .q_pop_o         (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .record_kind_o   (record_kind_o),
    .first_addr_o    (first_addr_o),
    .second_addr_o   (second_addr_o),
    .third_addr_o    (third_addr_o),
    .ends_with_call_o(ends_with_call_o),
    .ends_with_ret_o (ends_with_ret_o),
    .insn_len_o      (insn_len_o),
    .next_offset_o   (next_offset_o),
    .scan_done_o     (scan_done_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: x86 branch block scanner testbench
// Feeds code windows at the offsets the scanner asks for, predicts the step,
// syscall, block and loop records of every item and checks them in order.
// ----------------------------------------------------------------------------
module tb_top;
  import xbbs_pkg::*;

  localparam int unsigned BLOCK_CAP   = 4096;
  localparam int unsigned SYSCALL_CAP = 256;
  localparam int unsigned LOOP_CAP    = 128;
  localparam int unsigned IDLE_LIMIT  = 5000;

  typedef struct {
    rec_kind_e   kind;
    logic [63:0] a0;
    logic [63:0] a1;
    logic [63:0] a2;
    logic        call;
    logic        ret;
    logic [3:0]  len;
    logic [32:0] nxt;
    logic        done;
    logic        last;
  } scan_rec_t;

  typedef struct {
    logic [63:0] window;
    logic [3:0]  len;
  } window_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] code_window = '0;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = CFG_CODE_BASE;
  logic [63:0] cfg_wdata = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  record_kind;
  logic [63:0] first_addr, second_addr, third_addr;
  logic        ends_with_call, ends_with_ret;
  logic [3:0]  insn_len;
  logic [32:0] next_offset;
  logic        scan_done, last_of_run;

  // Shadow copy of the scanner state.
  logic [63:0] base_reg = '0;
  logic [31:0] size_reg = '0;
  logic [32:0] scan_pos = '0;
  logic [63:0] block_open = '0;
  int unsigned n_blocks = 0, n_syscalls = 0, n_loops = 0;
  logic        scan_over = 1'b0;

  scan_rec_t   pending_recs[$];
  scan_rec_t   step_recs[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  bit          steady = 1'b0;
  logic [3:0]  last_len;

  window_row_t directed_rows[] = '{
    '{64'h0123_4567_89AB_B848, 4'd10}, '{64'h0000_0000_0000_00C3, 4'd1},
    '{64'h0000_0000_0000_050F, 4'd2},  '{64'h0000_0000_0000_FE74, 4'd2},
    '{64'h0000_0000_0000_80EB, 4'd2},  '{64'h0000_0000_1000_00E8, 4'd5},
    '{64'h0000_007F_FFFF_FFE9, 4'd5},  '{64'h0000_8000_0000_840F, 4'd6},
    '{64'h00FF_FFFF_F085_0F41, 4'd7},  '{64'h0000_0000_0044_1F0F, 4'd5},
    '{64'h0000_0000_0080_1F0F, 4'd7},  '{64'h0000_0000_0084_1F0F, 4'd8},
    '{64'h0000_0000_0000_1F0F, 4'd3},  '{64'h0000_0000_0024_8481, 4'd11},
    '{64'h0000_0000_0000_0583, 4'd7},  '{64'h0000_0000_0000_C089, 4'd2},
    '{64'h0000_0000_0000_0050, 4'd1},  '{64'h0000_0000_0000_00CC, 4'd1},
    '{64'h0000_0000_0000_0090, 4'd1},  '{64'h0000_0000_0000_7FB0, 4'd2},
    '{64'h0000_0000_0000_B041, 4'd3},  '{64'h0000_0000_0045_FF4F, 4'd4},
    '{64'h0000_0000_0000_0000, 4'd3},  '{64'hFFFF_FFFF_FFFF_FFFF, 4'd2},
    '{64'h0000_0000_0000_00CB, 4'd1}
  };

  x86_branch_block_scanner dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .code_window_i(code_window),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .record_kind_o(record_kind), .first_addr_o(first_addr),
    .second_addr_o(second_addr), .third_addr_o(third_addr),
    .ends_with_call_o(ends_with_call), .ends_with_ret_o(ends_with_ret),
    .insn_len_o(insn_len), .next_offset_o(next_offset),
    .scan_done_o(scan_done), .last_of_run_o(last_of_run)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [7:0] code_byte(logic [63:0] w, int unsigned i);
    return w[8*(i%8) +: 8];
  endfunction

  function automatic logic [63:0] rel32_at(logic [63:0] w, int unsigned at);
    logic [31:0] d;
    d = w[8*at +: 32];
    return {{32{d[31]}}, d};
  endfunction

  function automatic int unsigned x86_len(logic [63:0] w, logic [63:0] rem);
    int unsigned op, rex, op2, m, md, rm, n, sb;
    rex = 0;
    if (rem == 0) return 1;
    op = code_byte(w, 0);
    if (op inside {[8'h40:8'h4F]} && rem > 1) begin
      rex = 1;
      op = code_byte(w, 1);
    end
    if (op inside {OP_RET, OP_RET_FAR, OP_INT3, OP_NOP}) return rex + 1;
    if (op inside {[8'h50:8'h5F]}) return rex + 1;
    if (op inside {[8'h70:8'h7F]} || op == OP_JMP8) return rex + 2;
    if (op == OP_CALL || op == OP_JMP32) return rex + 5;
    if (op == OP_TWO_BYTE && rem > rex + 1) begin
      op2 = code_byte(w, rex + 1);
      if (op2 == OP_SYSCALL2) return rex + 2;
      if (op2 inside {[8'h80:8'h8F]}) return rex + 6;
      if (op2 == OP_NOP_MODRM && rem > rex + 2) begin
        m = code_byte(w, rex + 2);
        sb = ((m & 7) == 4) ? 1 : 0;
        if ((m >> 6) == 0) return rex + 3 + sb;
        if ((m >> 6) == 1) return rex + 4 + sb;
        if ((m >> 6) == 2) return rex + 7 + sb;
      end
      return rex + 3;
    end
    if (op inside {[8'h80:8'h83], 8'h89, 8'h8B, 8'h8D, 8'h31, 8'h33, 8'h39, 8'h3B,
                   8'h85, 8'h01, 8'h03, 8'h29, 8'h09, 8'h0B, 8'h21, 8'h23, 8'hFF}) begin
      if (rem <= rex + 1) return rex + 2;
      m = code_byte(w, rex + 1);
      md = m >> 6;
      rm = m & 7;
      n = rex + 2;
      if (rm == 4 && md != 3) n++;
      if (md == 1) n += 1;
      if (md == 2 || (md == 0 && rm == 5)) n += 4;
      if (op inside {8'h80, 8'h82, 8'h83}) n += 1;
      if (op == 8'h81) n += 4;
      return n;
    end
    if (op inside {[8'hB8:8'hBF]}) return rex ? 10 : 5;
    if (op inside {[8'hB0:8'hB7]}) return rex + 2;
    return rex + 3;
  endfunction

  function automatic scan_rec_t blank_rec(rec_kind_e kind);
    scan_rec_t r;
    r = '{kind: kind, a0: '0, a1: '0, a2: '0, call: 1'b0, ret: 1'b0, len: '0,
          nxt: '0, done: 1'b0, last: 1'b0};
    return r;
  endfunction

  task automatic close_block(logic [63:0] start, logic [63:0] stop, logic [63:0] target,
                             logic call, logic ret);
    scan_rec_t r;
    if (n_blocks >= BLOCK_CAP) return;
    r = blank_rec(REC_BLOCK);
    r.a0 = start; r.a1 = stop; r.a2 = target; r.call = call; r.ret = ret;
    step_recs.push_back(r);
    n_blocks++;
    // A backward branch inside the text that is neither call nor ret is a loop.
    if (target != 0 && target < stop && target >= base_reg && !call && !ret &&
        n_loops < LOOP_CAP) begin
      r = blank_rec(REC_LOOP);
      r.a0 = target; r.a1 = start; r.a2 = stop;
      step_recs.push_back(r);
      n_loops++;
    end
  endtask

  task automatic predict_scan_step(logic [63:0] w);
    scan_rec_t   r;
    logic [63:0] rem, va, next_va, target, stop;
    int unsigned op, rex, len, b1;
    logic        br, call, ret, done;
    step_recs.delete();
    step_recs.push_back(blank_rec(REC_STEP));
    len = 0;
    if (scan_over) begin
      step_recs[0].nxt = scan_pos;
      step_recs[0].done = 1'b1;
      step_recs[0].last = 1'b1;
      pending_recs.push_back(step_recs[0]);
      last_len = 0;
      return;
    end
    if (scan_pos == 0) block_open = base_reg;
    if (scan_pos < {1'b0, size_reg} && n_blocks < BLOCK_CAP - 1) begin
      rem = {32'd0, size_reg} - 64'(scan_pos);
      va = base_reg + 64'(scan_pos);
      len = x86_len(w, rem);
      next_va = va + 64'(len);
      target = '0;
      br = 1'b0; call = 1'b0; ret = 1'b0; rex = 0;
      op = code_byte(w, 0);
      if (op inside {[8'h40:8'h4F]} && rem > 1) begin
        rex = 1;
        op = code_byte(w, 1);
      end
      b1 = code_byte(w, rex + 1);
      if (op == OP_TWO_BYTE && rem > rex + 1 && b1 == OP_SYSCALL2) begin
        if (n_syscalls < SYSCALL_CAP) begin
          r = blank_rec(REC_SYSCALL);
          r.a0 = va;
          step_recs.push_back(r);
          n_syscalls++;
        end
        br = 1'b1;
      end else if (op == OP_RET || op == OP_RET_FAR) begin
        ret = 1'b1; br = 1'b1;
      end else if (op inside {[8'h70:8'h7F]} || op == OP_JMP8) begin
        target = next_va + {{56{b1[7]}}, b1[7:0]};
        br = 1'b1;
      end else if (op == OP_CALL || op == OP_JMP32) begin
        target = next_va + rel32_at(w, rex + 1);
        call = (op == OP_CALL);
        br = 1'b1;
      end else if (op == OP_TWO_BYTE && rem > rex + 5 && b1 inside {[8'h80:8'h8F]}) begin
        // A near Jcc cut off by the text end keeps its length but is no branch.
        target = next_va + rel32_at(w, rex + 2);
        br = 1'b1;
      end
      if (br) begin
        close_block(block_open, next_va, target, call, ret);
        block_open = next_va;
      end
      scan_pos = scan_pos + 33'(len);
    end
    done = !(scan_pos < {1'b0, size_reg} && n_blocks < BLOCK_CAP - 1);
    if (done) begin
      stop = base_reg + 64'(scan_pos);
      if (block_open < stop) close_block(block_open, stop, '0, 1'b0, 1'b0);
      scan_over = 1'b1;
    end
    step_recs[0].len = 4'(len);
    step_recs[0].nxt = scan_pos;
    step_recs[0].done = done;
    step_recs[step_recs.size() - 1].last = 1'b1;
    foreach (step_recs[i]) pending_recs.push_back(step_recs[i]);
    last_len = 4'(len);
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    errors++;
  endtask

  // Random instruction with a random body, cut to zero past the text end.
  function automatic logic [63:0] random_window();
    logic [63:0] w, rem;
    logic [7:0]  ops[] = '{8'hC3, 8'hCB, 8'hCC, 8'h90, 8'h55, 8'h74, 8'hEB, 8'hE8, 8'hE9,
                           8'h0F, 8'h0F, 8'h0F, 8'h81, 8'h83, 8'h8B, 8'hFF, 8'hBA, 8'hB3};
    int unsigned k;
    w = {$urandom, $urandom};
    k = $urandom_range(0, 19);
    if (k < ops.size()) begin
      w[7:0] = ops[k];
      if (ops[k] == OP_TWO_BYTE) begin
        case ($urandom_range(0, 2))
          0: w[15:8] = OP_SYSCALL2;
          1: w[15:8] = 8'(8'h80 + $urandom_range(0, 15));
          default: w[15:8] = OP_NOP_MODRM;
        endcase
      end
      // Short backward branches make loops.
      if (ops[k] inside {8'h74, 8'hEB} && $urandom_range(0, 1)) w[15:8] = 8'hF0;
      if ($urandom_range(0, 3) == 0) w = {w[55:0], 8'(8'h40 + $urandom_range(0, 15))};
    end
    rem = (scan_pos < {1'b0, size_reg}) ? {32'd0, size_reg} - 64'(scan_pos) : 64'd0;
    for (int i = 0; i < 8; i++) begin
      if (rem <= i) w[8*i +: 8] = 8'h00;
    end
    return w;
  endfunction

  task automatic send_window(logic [63:0] w);
    int unsigned gap;
    in_valid <= 1'b1;
    code_window <= w;
    do @(posedge clk_i); while (in_stall);
    predict_scan_step(w);
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_recs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_CODE_BASE) base_reg = value;
    else size_reg = value[31:0];
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    scan_rec_t   want;
    int unsigned n;
    n = stall_left;
    if (out_valid && !out_stall) begin
      if (pending_recs.size() == 0) begin
        report_mismatch("unexpected record kind", record_kind, '0);
      end else begin
        want = pending_recs.pop_front();
        if (record_kind !== want.kind) report_mismatch("record_kind", record_kind, want.kind);
        if (first_addr !== want.a0) report_mismatch("first_addr", first_addr, want.a0);
        if (second_addr !== want.a1) report_mismatch("second_addr", second_addr, want.a1);
        if (third_addr !== want.a2) report_mismatch("third_addr", third_addr, want.a2);
        if (ends_with_call !== want.call)
          report_mismatch("ends_with_call", ends_with_call, want.call);
        if (ends_with_ret !== want.ret) report_mismatch("ends_with_ret", ends_with_ret, want.ret);
        if (insn_len !== want.len) report_mismatch("insn_len", insn_len, want.len);
        if (next_offset !== want.nxt) report_mismatch("next_offset", next_offset, want.nxt);
        if (scan_done !== want.done) report_mismatch("scan_done", scan_done, want.done);
        if (last_of_run !== want.last) report_mismatch("last_of_run", last_of_run, want.last);
      end
      n = steady ? 0 : $urandom_range(0, 4);
    end
    out_stall <= (n != 0);
    stall_left <= (n != 0) ? n - 1 : 0;
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Base near the top of the address space so addresses wrap.
    write_reg(CFG_CODE_BASE, 64'hFFFF_FFFF_FFFF_FFF0);
    write_reg(CFG_CODE_SIZE, 64'hFFFF_FFFF);
    foreach (directed_rows[i]) begin
      send_window(directed_rows[i].window);
      if (last_len != directed_rows[i].len)
        report_mismatch("directed length", last_len, directed_rows[i].len);
    end
    wait_drained();
    write_reg(CFG_CODE_BASE, 64'h0);
    steady = 1'b1;
    for (int i = 0; i < 30; i++) begin
      if (i == 15) steady = 1'b0;
      send_window(random_window());
    end
    wait_drained();
    write_reg(CFG_CODE_BASE, 64'h0000_7000_0040_0000);
    for (int i = 0; i < 30; i++) send_window(random_window());
    wait_drained();
    write_reg(CFG_CODE_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 30; i++) send_window(random_window());
    wait_drained();
    // Four bytes left: a near Jcc is cut short and the trailing block closes.
    write_reg(CFG_CODE_SIZE, 64'(scan_pos[31:0] + 32'd4));
    send_window(64'h0000_0000_0000_840F);
    for (int i = 0; i < 3; i++) send_window(random_window());
    wait_drained();
    write_reg(CFG_CODE_SIZE, 64'h0);
    write_reg(CFG_CODE_BASE, 64'h0);
    for (int i = 0; i < 2; i++) send_window(random_window());
    in_valid <= 1'b0;
    while (pending_recs.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/xbbs_pkg.sv
hw/rtl/xbbs_front.sv
hw/rtl/xbbs_queue.sv
hw/rtl/xbbs_back.sv
hw/rtl/x86_branch_block_scanner.sv
verif/tb_top.sv
